// ===== rtl/smd_pkg.sv =====
// shared types and constants for the sparsity map decompressor
package smd_pkg;

  localparam int DATA_W         = 16;
  localparam int LEN_W          = 5;
  localparam int WORD_BITS_DEF  = 16;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [LEN_W-1:0] MAP_LENGTH_RST = 5'd16;

  // kind of a queue entry: a 16-bit word or the end of one bus request
  typedef enum logic {
    KIND_WORD = 1'b0,
    KIND_MARK = 1'b1
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t       kind;
    logic              filler;
    logic              fin;
    logic [DATA_W-1:0] value;
  } entry_t;

  // one queue slot with its valid flag, used for push and for the head
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_slot_t;

endpackage

// ===== rtl/smd_front.sv =====
// front end: accepts bus requests and splits them into queue entries
module smd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // lower word, upper word
  input  logic [1:0]           in_tuser,   // lower word present, upper word present
  input  logic                 in_tlast,   // final_item
  output smd_pkg::q_slot_t     q_push,
  input  logic                 q_full
);
  import smd_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE   = 4'b0001,
    F_FIRST  = 4'b0010,
    F_SECOND = 4'b0100,
    F_MARK   = 4'b1000
  } front_state_t;

  front_state_t      state_r, state_nxt;
  logic [DATA_W-1:0] w0_r, w1_r;
  logic              v1_r, fin_r;
  logic              accept;

  assign in_tready = (state_r == F_IDLE);
  assign accept    = in_tvalid && in_tready;

  // request fields held while its entries are queued
  always_ff @(posedge clk) begin
    if (accept) begin
      w0_r  <= in_tdata[DATA_W-1:0];
      w1_r  <= in_tdata[2*DATA_W-1:DATA_W];
      v1_r  <= in_tuser[1];
      fin_r <= in_tlast;
    end
  end

  // sequencing of word, word, end mark
  always_comb begin
    state_nxt           = state_r;
    q_push.valid        = 1'b0;
    q_push.entry.kind   = KIND_WORD;
    q_push.entry.filler = 1'b0;
    q_push.entry.fin    = fin_r;
    q_push.entry.value  = w0_r;
    case (state_r)
      F_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0]) begin
            state_nxt = F_FIRST;
          end else if (in_tuser[1]) begin
            state_nxt = F_SECOND;
          end else begin
            state_nxt = F_MARK;
          end
        end
      end
      F_FIRST: begin
        q_push.valid        = !q_full;
        q_push.entry.filler = fin_r && !v1_r;
        if (!q_full) begin
          state_nxt = v1_r ? F_SECOND : F_MARK;
        end
      end
      F_SECOND: begin
        q_push.valid        = !q_full;
        q_push.entry.filler = fin_r;
        q_push.entry.value  = w1_r;
        if (!q_full) begin
          state_nxt = F_MARK;
        end
      end
      F_MARK: begin
        q_push.valid      = !q_full;
        q_push.entry.kind = KIND_MARK;
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/smd_fifo.sv =====
// short entry queue between front end and expansion engine
module smd_fifo #(
  parameter int DEPTH = smd_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  smd_pkg::q_slot_t q_push,
  output logic             q_full,
  output smd_pkg::q_slot_t q_head,
  input  logic             q_pop
);
  import smd_pkg::*;

  // depth is a power of two, pointers wrap on their own
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign q_full       = (cnt_r == CNT_W'(DEPTH));
  assign q_head.valid = (cnt_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];
  assign do_push      = q_push.valid && !q_full;
  assign do_pop       = q_pop && q_head.valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/smd_back.sv =====
// expansion engine: walks map bits and emits at most one dense value per cycle, holding while the output is stalled
module smd_back #(
  parameter int WORD_BITS = smd_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [smd_pkg::LEN_W-1:0]         map_length,
  input  smd_pkg::q_slot_t                  q_head,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic signed [smd_pkg::DATA_W-1:0] out_tdata,  // pixel_value
  output logic                              out_tlast   // last_of_run
);
  import smd_pkg::*;

  localparam int               IDX_W  = $clog2(WORD_BITS);
  localparam logic [LEN_W-1:0] WB_LEN = LEN_W'(WORD_BITS);

  logic [WORD_BITS-1:0] map_bits_r, map_bits_nxt;
  logic [LEN_W-1:0]     pos_r, pos_nxt;
  logic                 zrun_r, zrun_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [DATA_W-1:0]    pend_value_r, pend_value_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     pos_inc;
  logic [IDX_W-1:0]     idx;
  logic [WORD_BITS-1:0] head_map;
  logic                 out_free;
  logic                 go;
  logic                 emit;
  logic [DATA_W-1:0]    emit_val;
  logic                 out_push;
  logic                 out_push_last;
  logic                 is_mark;

  assign len      = (map_length > WB_LEN) ? WB_LEN : map_length;
  assign pos_inc  = pos_r + 1'b1;
  assign idx      = pos_r[IDX_W-1:0];
  assign head_map = q_head.entry.value[WORD_BITS-1:0];
  assign out_free = !out_valid_r || out_tready;
  assign go       = !pend_valid_r || out_free;
  assign is_mark  = (q_head.entry.kind == KIND_MARK);

  // one step on the queue head
  always_comb begin
    map_bits_nxt  = map_bits_r;
    pos_nxt       = pos_r;
    zrun_nxt      = zrun_r;
    q_pop         = 1'b0;
    emit          = 1'b0;
    emit_val      = '0;
    out_push      = 1'b0;
    out_push_last = 1'b0;
    if (q_head.valid) begin
      if (is_mark) begin
        // end of request: release the held value as last of run
        if (go) begin
          q_pop         = 1'b1;
          out_push      = pend_valid_r;
          out_push_last = 1'b1;
          if (q_head.entry.fin) begin
            map_bits_nxt = '0;
            pos_nxt      = map_length;
          end
        end
      end else if (zrun_r) begin
        // zero map expanding to a run of zeros
        emit = 1'b1;
        if (go) begin
          pos_nxt = pos_inc;
          if (pos_inc == len) begin
            zrun_nxt = 1'b0;
            q_pop    = 1'b1;
          end
        end
      end else if (pos_r >= len) begin
        // word taken as a new map
        map_bits_nxt = head_map;
        pos_nxt      = '0;
        if (head_map == '0) begin
          if (!q_head.entry.filler && (len != '0)) begin
            zrun_nxt = 1'b1;
          end else begin
            pos_nxt = len;
            q_pop   = 1'b1;
          end
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        // scan one map position; a clear bit at the end turns the word into a map
        emit = 1'b1;
        if (map_bits_r[idx]) begin
          emit_val = q_head.entry.value;
        end
        if (go) begin
          pos_nxt = pos_inc;
          if (map_bits_r[idx]) begin
            map_bits_nxt[idx] = 1'b0;
            q_pop             = 1'b1;
          end
        end
      end
    end
    // a held result moves on when a new one takes its place
    if (emit && go) begin
      out_push = pend_valid_r;
    end
  end

  // one-result hold so the last result of a request can be marked
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_value_nxt = pend_value_r;
    if (emit && go) begin
      pend_valid_nxt = 1'b1;
      pend_value_nxt = emit_val;
    end else if (q_pop && is_mark) begin
      pend_valid_nxt = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (out_push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pend_value_r;
      out_last_nxt  = out_push_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_bits_r   <= '0;
      pos_r        <= MAP_LENGTH_RST;
      zrun_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      map_bits_r   <= map_bits_nxt;
      pos_r        <= pos_nxt;
      zrun_r       <= zrun_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_value_r <= pend_value_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // a result is only loaded when the output register can take it
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> out_free)
    else $error("result loaded into a busy output register");

  // an end mark leaves nothing held
  a_mark_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.valid && is_mark) |=> !pend_valid_r)
    else $error("held result survived the end of a request");

  // a zero run only follows an all-zero map
  a_zrun_map: assert property (@(posedge clk) disable iff (!rst_n)
    zrun_r |-> (map_bits_r == '0))
    else $error("zero run with map bits set");

  // a request end is never popped behind a running zero run
  a_zrun_head: assert property (@(posedge clk) disable iff (!rst_n)
    (zrun_r && q_head.valid) |-> !is_mark)
    else $error("end mark at head during zero run");

endmodule

// ===== rtl/sparsity_map_decompressor.sv =====
// Sparsity map decompressor: each accepted request carries two 16-bit words with present
// flags; present words form a stream of maps, each followed by one value per set bit, and
// the block expands them into dense signed values, one per cycle while the output is not
// stalled, with out_tlast on the last result of each request. After accepting a request the
// front end holds in_tready low while it queues each present word and then the end mark,
// waiting while the queue is full, so the input port takes no new request until those
// entries are queued. The expansion engine takes a step for each present word taken as a
// map, for each dense value emitted and to close the request; the engine, at one dense value
// per cycle, sets the sustained rate. A queue of FIFO_DEPTH entries lets the input side run
// ahead while the output is stalled. map_length is written through cfg_wen/cfg_wdata; the
// user must write it only while the block is idle, as the block does not enforce this.
module sparsity_map_decompressor #(
  parameter int WORD_BITS  = smd_pkg::WORD_BITS_DEF,
  parameter int FIFO_DEPTH = smd_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wen,
  input  logic [smd_pkg::LEN_W-1:0]         cfg_wdata,  // map_length
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // lower word, upper word
  input  logic [1:0]                        in_tuser,   // lower present, upper present
  input  logic                              in_tlast,   // final_item
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic signed [smd_pkg::DATA_W-1:0] out_tdata,  // pixel_value
  output logic                              out_tlast   // last_of_run
);
  import smd_pkg::*;

  logic [LEN_W-1:0] map_length_r;
  q_slot_t          q_push;
  q_slot_t          q_head;
  logic             q_full;
  logic             q_pop;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_length_r <= MAP_LENGTH_RST;
    end else if (cfg_wen) begin
      map_length_r <= cfg_wdata;
    end
  end

  smd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_push    (q_push),
    .q_full    (q_full)
  );

  smd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  smd_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .map_length (map_length_r),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the sparsity map decompressor
`timescale 1ns / 100ps

module tb;

  import smd_pkg::*;

  localparam int          MAP_WORD_BITS = WORD_BITS_DEF;
  localparam int          DRAIN_CYCLES  = 64;
  localparam int          PHASE_ITEMS   = 40;
  localparam int          NUM_PHASES    = 9;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;

  // one expected dense value with its end-of-request flag
  typedef struct packed {
    logic [DATA_W-1:0] pixel;
    logic              last;
  } pixel_t;

  // running copy of the expansion state, expected pixels and checking
  class pixel_scoreboard;
    logic [LEN_W-1:0] map_length;
    logic [15:0]      map_bits;
    int unsigned      map_pos;
    pixel_t           pending_pixels[$];
    int unsigned      mismatches;

    function new();
      map_length = MAP_LENGTH_RST;
      map_bits   = '0;
      map_pos    = MAP_LENGTH_RST;
      mismatches = 0;
    endfunction

    function void set_length(logic [LEN_W-1:0] len);
      map_length = len;
    endfunction

    // lengths above the word width saturate
    function int unsigned active_len();
      return (map_length > MAP_WORD_BITS) ? MAP_WORD_BITS : map_length;
    endfunction

    function void push_pixel(logic [DATA_W-1:0] value);
      pixel_t p;
      p.pixel = value;
      p.last  = 1'b0;
      pending_pixels.insert(pending_pixels.size(), p);
    endfunction

    // a zero map expands to a full run of zeros unless it is stream filler
    function void load_map(logic [15:0] word, bit filler);
      int unsigned len;
      len      = active_len();
      map_bits = word;
      map_pos  = 0;
      if (map_bits == '0) begin
        if (!filler) repeat (len) push_pixel('0);
        map_pos = len;
      end
    endfunction

    // walk the map from the current position until a set bit takes the word
    function void take_word(logic [15:0] word, bit filler);
      int unsigned len;
      int unsigned i;
      len = active_len();
      if (map_pos >= len) begin
        load_map(word, filler);
        return;
      end
      for (i = map_pos; i < len; i++) begin
        map_pos = i + 1;
        if (map_bits[i]) begin
          map_bits[i] = 1'b0;
          push_pixel(word);
          return;
        end
        push_pixel('0);
        if (map_pos == len) begin
          load_map(word, filler);
          return;
        end
      end
    endfunction

    // expected pixels of one accepted request
    function void note_request(logic [15:0] fv, bit f_ok, logic [15:0] sv, bit s_ok,
                               bit fin);
      int unsigned start;
      start = pending_pixels.size();
      if (f_ok) take_word(fv, fin && !s_ok);
      if (s_ok) take_word(sv, fin);
      if (pending_pixels.size() > start) begin
        pending_pixels[pending_pixels.size() - 1].last = 1'b1;
      end
      if (fin) begin
        map_bits = '0;
        map_pos  = map_length;
      end
    endfunction

    function void check_pixel(logic [DATA_W-1:0] pixel, logic last);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel %h last %b", pixel, last);
        return;
      end
      want = pending_pixels.pop_front();
      if (want.pixel !== pixel || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected %h last %b, got %h last %b",
                   want.pixel, want.last, pixel, last);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n       = 1'b0;
  logic                     cfg_wen     = 1'b0;
  logic [LEN_W-1:0]         cfg_wdata   = '0;
  logic                     in_tvalid   = 1'b0;
  logic                     in_tready;
  logic [31:0]              in_tdata    = '0;  // lower word, upper word
  logic [1:0]               in_tuser    = '0;  // lower present, upper present
  logic                     in_tlast    = 1'b0;  // final_item
  logic                     out_tvalid;
  logic                     out_tready  = 1'b0;
  logic signed [DATA_W-1:0] out_tdata;  // pixel_value
  logic                     out_tlast;  // last_of_run

  int unsigned      send_idle     = 6;
  int unsigned      recv_idle     = 81;
  int unsigned      requests_sent = 0;
  int unsigned      cycles        = 0;
  logic [LEN_W-1:0] phase_len [NUM_PHASES] = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd7,
                                               5'd2, 5'd16, 5'd16};

  pixel_scoreboard sb = new();

  sparsity_map_decompressor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: check accepted pixels, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // one input request, held until accepted
  task automatic send_request(input logic [15:0] fv, input bit f_ok, input logic [15:0] sv,
                              input bit s_ok, input bit fin);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sv, fv};
    in_tuser  <= {s_ok, f_ok};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(fv, f_ok, sv, s_ok, fin);
    if (f_ok || s_ok) requests_sent++;
  endtask

  // well-formed compressed stream: maps with their values, packed into requests
  task automatic send_frame();
    logic [15:0] words[$];
    logic [15:0] mask;
    logic [15:0] map;
    logic [15:0] fv;
    logic [15:0] sv;
    bit          f_ok;
    bit          s_ok;
    bit          fin_frame;
    int unsigned len;
    int unsigned pick;
    len  = sb.active_len();
    mask = (len >= 16) ? 16'hFFFF : 16'((32'd1 << len) - 1);
    repeat ($urandom_range(1, 3)) begin
      pick = $urandom_range(19);
      if (pick == 0) map = '0;
      else if (pick == 1) map = mask;
      else if (pick == 2) map = 16'($urandom);
      else map = 16'($urandom) & mask;
      words.insert(words.size(), map);
      repeat ($countones(map & mask)) words.insert(words.size(), 16'($urandom));
    end
    fin_frame = ($urandom_range(3) != 0);
    // zero filler padding the tail of the stream
    if (fin_frame && $urandom_range(1)) words.insert(words.size(), 16'h0000);
    while (words.size() > 0) begin
      pick = $urandom_range(19);
      fv   = 16'($urandom);
      sv   = 16'($urandom);
      f_ok = 1'b0;
      s_ok = 1'b0;
      if (pick == 0) begin
        // empty request, ignored by the block
      end else if (pick <= 3) begin
        fv   = words.pop_front();
        f_ok = 1'b1;
      end else if (pick <= 6 || words.size() == 1) begin
        sv   = words.pop_front();
        s_ok = 1'b1;
      end else begin
        fv   = words.pop_front();
        sv   = words.pop_front();
        f_ok = 1'b1;
        s_ok = 1'b1;
      end
      send_request(fv, f_ok, sv, s_ok, fin_frame && words.size() == 0);
    end
  endtask

  // wait for every expected pixel, then let the engine settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg_wen   <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    sb.set_length(len);
    cfg_wen   <= 1'b0;
  endtask

  // stimulus
  initial begin
    int unsigned phase;
    int unsigned target;
    logic [LEN_W-1:0] len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at the reset length
    send_request(16'h8001, 1, 16'h7FFF, 1, 0);  // map with end bits, extreme value
    send_request(16'h8000, 1, 16'h0000, 1, 0);  // leading zeros then a zero map
    send_request(16'h0002, 1, 16'hABCD, 0, 0);  // map alone
    send_request(16'h1357, 0, 16'hFFFF, 1, 0);  // value in the upper half only
    send_request(16'hAAAA, 0, 16'h5555, 0, 0);  // nothing present
    send_request(16'h0001, 1, 16'h1234, 1, 0);  // trailing clear bits left pending
    send_request(16'h0000, 1, 16'hFFFF, 0, 1);  // flush then zero filler
    send_request(16'h0000, 1, 16'h0000, 1, 1);  // zero map then zero filler
    send_request(16'h0003, 1, 16'h5555, 1, 1);  // pending position dropped at end
    send_request(16'h0001, 1, 16'h0000, 0, 1);  // final request holding a map only
    send_request(16'h0001, 1, 16'h00AA, 1, 0);
    send_request(16'h0000, 1, 16'h0000, 1, 0);  // longest expansion of one request
    send_request(16'hFFFF, 1, 16'h8000, 1, 0);
    send_request(16'h7FFF, 1, 16'h0001, 1, 0);
    send_request(16'h8000, 1, 16'h0000, 1, 1);
    send_request(16'h8000, 1, 16'h7FFF, 0, 0);  // map left open for a length change
    drain();

    // random phases over several map lengths and idle patterns
    target = requests_sent;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      len = (phase == NUM_PHASES - 1) ? LEN_W'($urandom_range(1, 16)) : phase_len[phase];
      if (phase < 3) begin
        send_idle <= 6;
        recv_idle <= 81;
      end else if (phase < 6) begin
        send_idle <= 81;
        recv_idle <= 6;
      end else begin
        send_idle <= 0;
        recv_idle <= 0;
      end
      write_length(len);
      target += PHASE_ITEMS;
      while (requests_sent < target) begin
        if ($urandom_range(9) < 8) begin
          send_frame();
        end else begin
          // noise: arbitrary words and flags
          send_request(16'($urandom), $urandom_range(1), 16'($urandom), $urandom_range(1),
                       $urandom_range(3) == 0);
        end
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/smd_pkg.sv
rtl/smd_front.sv
rtl/smd_fifo.sv
rtl/smd_back.sv
rtl/sparsity_map_decompressor.sv
test/tb.sv
